FILE: design/adcseg_pkg.sv
// Package for the ADC sample to seven-segment digit converter.
// Holds segment codes, range limits and the constant-divider table.
// No dependencies.
`default_nettype none

package adcseg_pkg;

  localparam int SAMPLE_BITS_DEF = 10;

  localparam logic [7:0] SEG_DASH  = 8'h01;
  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_DP    = 8'h80;

  localparam logic [9:0] ZERO_POINT = 10'd480;
  localparam logic [9:0] TOP_LIMIT  = 10'd955;
  localparam logic [9:0] LOW_LIMIT  = 10'd2;

  // Upper bounds of the positive gain segments.
  localparam logic [9:0] SEG1_TOP = 10'd611;
  localparam logic [9:0] SEG2_TOP = 10'd677;
  localparam logic [9:0] SEG3_TOP = 10'd743;
  localparam logic [9:0] SEG4_TOP = 10'd875;

  // Reciprocal shift: products n*A stay below 2^19, so floor(p*R >> 20)
  // is the true quotient or one less.
  localparam int RECIP_SHIFT = 20;

  localparam logic [16:0] RECIP_1323 = 17'((2 ** RECIP_SHIFT) / 1323);
  localparam logic [16:0] RECIP_13   = 17'((2 ** RECIP_SHIFT) / 13);
  localparam logic [16:0] RECIP_131  = 17'((2 ** RECIP_SHIFT) / 131);
  localparam logic [16:0] RECIP_1315 = 17'((2 ** RECIP_SHIFT) / 1315);
  localparam logic [16:0] RECIP_1316 = 17'((2 ** RECIP_SHIFT) / 1316);
  localparam logic [16:0] RECIP_1319 = 17'((2 ** RECIP_SHIFT) / 1319);

  // Gain selection: v = floor(n * numer / denom).
  typedef enum logic [2:0] {
    GAIN_NEG  = 3'd0,  // 1000 / 1323
    GAIN_13   = 3'd1,  // 10 / 13
    GAIN_131  = 3'd2,  // 100 / 131
    GAIN_1315 = 3'd3,  // 1000 / 1315
    GAIN_1316 = 3'd4,  // 1000 / 1316
    GAIN_1319 = 3'd5   // 1000 / 1319
  } gain_sel_t;

  typedef struct packed {
    logic [9:0]  numer;
    logic [10:0] denom;
    logic [16:0] recip;
  } gain_t;

  function automatic gain_t gain_of(input gain_sel_t sel);
    gain_t g;
    unique case (sel)
      GAIN_NEG:  g = '{numer: 10'd1000, denom: 11'd1323, recip: RECIP_1323};
      GAIN_13:   g = '{numer: 10'd10,   denom: 11'd13,   recip: RECIP_13};
      GAIN_131:  g = '{numer: 10'd100,  denom: 11'd131,  recip: RECIP_131};
      GAIN_1315: g = '{numer: 10'd1000, denom: 11'd1315, recip: RECIP_1315};
      GAIN_1316: g = '{numer: 10'd1000, denom: 11'd1316, recip: RECIP_1316};
      GAIN_1319: g = '{numer: 10'd1000, denom: 11'd1319, recip: RECIP_1319};
      default:   g = '{numer: 10'd0,    denom: 11'd1,    recip: 17'd0};
    endcase
    return g;
  endfunction

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] s;
    case (digit)
      4'd0:    s = 8'h7E;
      4'd1:    s = 8'h30;
      4'd2:    s = 8'h6D;
      4'd3:    s = 8'h79;
      4'd4:    s = 8'h33;
      4'd5:    s = 8'h5B;
      4'd6:    s = 8'h5F;
      4'd7:    s = 8'h70;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h7B;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: design/adc_reading_to_segment_digits_unit.sv
// ADC sample to seven-segment digits, fully pipelined.
// Depends on adcseg_pkg (segment table, limits, divider constants).
`default_nettype none

// Usage:
//   Issue a transaction by raising start with adc_sample valid; it is taken
//   at any clock edge where start is high, and busy is always low, so a new
//   sample may be issued every cycle.
//   Each sample yields one result: done is high for exactly one cycle, with
//   the four segment bytes, shown_value and out_of_range valid in that cycle.
//   The block takes one sample per cycle. The path is 8 register stages:
//   input sample, range decode, gain multiply, reciprocal multiply,
//   remainder check, quotient correction, hundreds split, and tens/ones
//   split with segment encode.
//   The receiver cannot stall the block; results are not held.
//   Reset (rst, synchronous) clears all stage valid bits, so nothing in
//   flight is delivered; payload registers are not cleared.
//   Samples at or below 2, or above 955, show four dashes and set
//   out_of_range; shown_value is then zero.
module adc_reading_to_segment_digits_unit #(
  parameter int SAMPLE_BITS = adcseg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [SAMPLE_BITS-1:0] adc_sample,
  output logic                        done,
  output logic [7:0]                  sign_pattern,
  output logic [7:0]                  hundreds_pattern,
  output logic [7:0]                  tens_pattern,
  output logic [7:0]                  ones_pattern,
  output logic [9:0]                  shown_value,
  output logic                        out_of_range
);
  import adcseg_pkg::*;

  localparam int STAGES = 7;

  logic [STAGES-1:0] vld;
  // Flags that ride along every stage.
  logic [STAGES-1:0] neg_flag;
  logic [STAGES-1:0] oor_flag;

  // Stage 1: registered sample
  logic [SAMPLE_BITS-1:0] sample;

  // Stage 2: magnitude and gain select
  logic [8:0]  mag;
  gain_sel_t   sel2;
  logic [8:0]  mag_next;
  gain_sel_t   sel_next;
  logic        neg_next;
  logic        oor_next;
  logic [9:0]  xs;

  // Stage 3: numerator product
  logic [18:0] prod_p;
  gain_t       g3;
  gain_t       g2;

  // Stage 4: estimated quotient
  logic [35:0] recip_prod;
  logic [8:0]  q_est;
  logic [18:0] p4;
  logic [10:0] denom4;

  // Stage 5: remainder
  logic [19:0] qb;
  logic [11:0] rem5;
  logic [8:0]  q5;
  logic [8:0]  quot5;
  logic [10:0] denom5;

  // Stage 6: corrected value
  logic [8:0]  val6;

  // Stage 7: hundreds and low part
  logic [1:0]  hund7;
  logic [6:0]  low7;
  logic [8:0]  val7;
  logic [1:0]  hund_next;
  logic [8:0]  hund_sub;

  logic [14:0] tens_prod;
  logic [3:0]  tens_dig;
  logic [6:0]  tens_x10;
  logic [3:0]  ones_dig;

  assign busy = 1'b0;
  assign xs   = sample[9:0];

  // Range decode and magnitude.
  always_comb begin
    oor_next = 1'b0;
    neg_next = 1'b0;
    sel_next = GAIN_NEG;
    mag_next = '0;
    if ((sample <= SAMPLE_BITS'(LOW_LIMIT)) || (sample > SAMPLE_BITS'(TOP_LIMIT))) begin
      oor_next = 1'b1;
    end else if (xs < ZERO_POINT) begin
      // 479 gives floor(1000/1323) = 0, so it shares the negative path.
      neg_next = (xs != ZERO_POINT - 10'd1);
      mag_next = 9'(ZERO_POINT - xs);
    end else begin
      mag_next = 9'(xs - ZERO_POINT);
      if (xs <= SEG1_TOP) begin
        sel_next = GAIN_13;
      end else if (xs <= SEG2_TOP) begin
        sel_next = GAIN_131;
      end else if (xs <= SEG3_TOP) begin
        sel_next = GAIN_1315;
      end else if (xs <= SEG4_TOP) begin
        sel_next = GAIN_1316;
      end else begin
        sel_next = GAIN_1319;
      end
    end
  end

  assign g2 = gain_of(sel2);

  assign recip_prod = 36'(prod_p) * 36'(g3.recip);
  assign q_est      = recip_prod[RECIP_SHIFT+8:RECIP_SHIFT];

  assign qb = 20'(q5) * 20'(denom4);

  always_comb begin
    if (val6 >= 9'd300) begin
      hund_next = 2'd3;
    end else if (val6 >= 9'd200) begin
      hund_next = 2'd2;
    end else if (val6 >= 9'd100) begin
      hund_next = 2'd1;
    end else begin
      hund_next = 2'd0;
    end
    hund_sub = val6 - 9'(hund_next) * 9'd100;
  end

  // floor(x/10) as (x*205) >> 11, exact for x below 100.
  assign tens_prod = 15'(low7) * 15'd205;
  assign tens_dig  = tens_prod[14:11];
  assign tens_x10  = 7'(tens_dig) * 7'd10;
  assign ones_dig  = 4'(low7 - tens_x10);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[STAGES-2:0], start & ~busy};
      done <= vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    sample <= adc_sample;

    mag         <= mag_next;
    sel2        <= sel_next;
    neg_flag[1] <= neg_next;
    oor_flag[1] <= oor_next;

    prod_p <= 19'(mag) * 19'(g2.numer);
    g3     <= g2;

    p4     <= prod_p;
    q5     <= q_est;
    denom4 <= g3.denom;

    denom5 <= denom4;
    quot5  <= q5;
    rem5   <= 12'(p4 - qb[18:0]);

    val6 <= (rem5 >= 12'(denom5)) ? quot5 + 9'd1 : quot5;

    hund7 <= hund_next;
    low7  <= 7'(hund_sub);
    val7  <= val6;

    for (int i = 2; i < STAGES; i++) begin
      neg_flag[i] <= neg_flag[i-1];
      oor_flag[i] <= oor_flag[i-1];
    end
    neg_flag[0] <= 1'b0;
    oor_flag[0] <= 1'b0;

    if (oor_flag[STAGES-1]) begin
      sign_pattern     <= SEG_DASH;
      hundreds_pattern <= SEG_DASH;
      tens_pattern     <= SEG_DASH | SEG_DP;
      ones_pattern     <= SEG_DASH;
      shown_value      <= '0;
      out_of_range     <= 1'b1;
    end else begin
      sign_pattern     <= neg_flag[STAGES-1] ? SEG_DASH : SEG_BLANK;
      hundreds_pattern <= seg_of(4'(hund7));
      tens_pattern     <= seg_of(tens_dig) | SEG_DP;
      ones_pattern     <= seg_of(ones_dig);
      shown_value      <= 10'(val7);
      out_of_range     <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_adc_reading_to_segment_digits_unit.sv
// Testbench for adc_reading_to_segment_digits_unit: drives converter samples and
// checks each segment result against an in-bench model of the scaling.
// Depends on adcseg_pkg and the unit under test.
`timescale 1ns / 1ps

module tb_adc_reading_to_segment_digits_unit;
  import adcseg_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 40;
  localparam int RANDOM_ITEMS = 2000;

  // Digit segment codes, index 0 is the rightmost byte.
  localparam logic [9:0][7:0] DIGIT_SEGMENTS = {
    8'h7B, 8'h7F, 8'h70, 8'h5F, 8'h5B, 8'h33, 8'h79, 8'h6D, 8'h30, 8'h7E
  };

  typedef struct {
    logic [7:0] sign_seg;
    logic [7:0] hundreds_seg;
    logic [7:0] tens_seg;
    logic [7:0] ones_seg;
    logic [9:0] magnitude;
    logic       oor;
  } segment_result_t;

  typedef struct {
    logic [9:0] sample;
    int         idle_pct;
    bit         wait_drain;
  } sample_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [9:0] adc_sample = '0;
  logic       busy;
  logic       done;
  logic [7:0] sign_pattern;
  logic [7:0] hundreds_pattern;
  logic [7:0] tens_pattern;
  logic [7:0] ones_pattern;
  logic [9:0] shown_value;
  logic       out_of_range;

  sample_item_t    pending_samples[$];
  segment_result_t expected_digits[$];
  int unsigned     outstanding = 0;
  int unsigned     issued_count = 0;
  int unsigned     checked_count = 0;
  int unsigned     oor_count = 0;
  int unsigned     minus_count = 0;
  int unsigned     fail_count = 0;
  int unsigned     cycle_count = 0;

  adc_reading_to_segment_digits_unit uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .adc_sample       (adc_sample),
    .done             (done),
    .sign_pattern     (sign_pattern),
    .hundreds_pattern (hundreds_pattern),
    .tens_pattern     (tens_pattern),
    .ones_pattern     (ones_pattern),
    .shown_value      (shown_value),
    .out_of_range     (out_of_range)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic segment_result_t predict_segments(input logic [9:0] x);
    segment_result_t r;
    int unsigned xi;
    int unsigned diff;
    int unsigned scaled;
    int unsigned tenths;
    xi = x;
    tenths = 0;
    if (xi <= LOW_LIMIT || xi > TOP_LIMIT) begin
      r.sign_seg     = SEG_DASH;
      r.hundreds_seg = SEG_DASH;
      r.tens_seg     = SEG_DASH | SEG_DP;
      r.ones_seg     = SEG_DASH;
      r.magnitude    = '0;
      r.oor          = 1'b1;
      return r;
    end
    if (xi < ZERO_POINT - 1) begin
      r.sign_seg = SEG_DASH;
      tenths = ((ZERO_POINT - xi) * 1000) / 1323;
    end else if (xi == ZERO_POINT - 1) begin
      r.sign_seg = SEG_BLANK;
    end else begin
      r.sign_seg = SEG_BLANK;
      diff = xi - ZERO_POINT;
      if (xi <= SEG1_TOP)      scaled = (diff * 100) / 13;
      else if (xi <= SEG2_TOP) scaled = (diff * 1000) / 131;
      else if (xi <= SEG3_TOP) scaled = (diff * 10000) / 1315;
      else if (xi <= SEG4_TOP) scaled = (diff * 10000) / 1316;
      else                     scaled = (diff * 10000) / 1319;
      tenths = scaled / 10;
    end
    r.hundreds_seg = DIGIT_SEGMENTS[(tenths % 1000) / 100];
    r.tens_seg     = DIGIT_SEGMENTS[(tenths % 100) / 10] | SEG_DP;
    r.ones_seg     = DIGIT_SEGMENTS[tenths % 10];
    r.magnitude    = tenths[9:0];
    r.oor          = 1'b0;
    return r;
  endfunction

  task automatic report_field(input string field, input logic [9:0] want,
                              input logic [9:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // Driver: a new sample may go out whenever the previous one was taken.
  always @(posedge clk) begin : drive
    sample_item_t item;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_samples.size() == 0) begin
        start <= 1'b0;
      end else if (pending_samples[0].wait_drain && (outstanding != 0 || start)) begin
        // hold until the pipeline has delivered everything
        start <= 1'b0;
      end else if ($urandom_range(99) < pending_samples[0].idle_pct) begin
        start <= 1'b0;
      end else begin
        item = pending_samples.pop_front();
        adc_sample <= item.sample;
        start <= 1'b1;
        issued_count++;
      end
    end
  end

  // Monitor: record accepted samples, check every done strobe in order.
  always @(posedge clk) begin : check
    segment_result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_digits.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result with no transaction outstanding, value %h",
                     $time, shown_value);
        end else begin
          want = expected_digits.pop_front();
          report_field("sign_pattern", want.sign_seg, sign_pattern);
          report_field("hundreds_pattern", want.hundreds_seg, hundreds_pattern);
          report_field("tens_pattern", want.tens_seg, tens_pattern);
          report_field("ones_pattern", want.ones_seg, ones_pattern);
          report_field("shown_value", want.magnitude, shown_value);
          report_field("out_of_range", want.oor, out_of_range);
          checked_count++;
          if (want.oor) oor_count++;
          else if (want.sign_seg == SEG_DASH) minus_count++;
        end
      end
      if (start && !busy)
        expected_digits.push_back(predict_segments(adc_sample));
      outstanding <= expected_digits.size();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_sample(input int unsigned s, input int pct, input bit drain);
    sample_item_t item;
    item.sample     = s[9:0];
    item.idle_pct   = pct;
    item.wait_drain = drain;
    pending_samples.push_back(item);
  endtask

  initial begin : stimulus
    int unsigned directed_pts[24];
    int unsigned boundary_pts[15];
    int unsigned s;
    int pct;
    directed_pts = '{0, 1, 2, 3, 4, 478, 479, 480, 481, 611, 612, 677, 678, 743,
                     744, 875, 876, 954, 955, 956, 1023, 512, 341, 682};
    boundary_pts = '{2, 3, 478, 479, 480, 611, 612, 677, 678, 743, 744, 875, 876,
                     955, 956};

    foreach (directed_pts[i]) queue_sample(directed_pts[i], 0, 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pct = (i < 700) ? 24 : (i < 1400) ? 48 : 0;
      case ($urandom_range(19))
        0, 1, 2:  s = $urandom_range(1023);
        3, 4, 5:  s = boundary_pts[$urandom_range(14)] + $urandom_range(6) - 3;
        default:  s = $urandom_range(955, 3);
      endcase
      queue_sample(s, pct, (i % 400 == 0) || i == 700 || i == 1400);
    end

    @(negedge clk);
    while (rst || pending_samples.size() != 0 || start || outstanding != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Issued %0d samples, checked %0d results (%0d negative, %0d out of range).",
             issued_count, checked_count, minus_count, oor_count);
    $display("Sender gaps at 24%% and 48%%, then back to back, with pipeline drains.");
    if (fail_count == 0 && expected_digits.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, expected_digits.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
